@@ rtl/core/nnc_pkg.sv @@
package nnc_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int CLASS_BITS_DEF  = 8;

   localparam int HU_COUNT   = 7;
   localparam int FEAT_COUNT = HU_COUNT + 2;
   localparam int FEAT_W     = 24;
   localparam int SQ_W       = 2 * FEAT_W;
   localparam int PART_W     = SQ_W + 2;
   localparam int DIST_W     = 52;
   localparam int REQ_W      = 2;
   localparam int STATUS_W   = 2;

   // One feature vector, element 0 is the first Hu moment.
   typedef logic [FEAT_COUNT-1:0][FEAT_W-1:0] feat_vec_type;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD  = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_LOADED   = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_ANSWERED = 2'd2,
      STAT_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // Controls handed to every storage cell.
   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctl_type;

endpackage

@@ rtl/core/nnc_if.sv @@
interface nnc_req_if #(
   parameter int CLASS_BITS = 8
);
   import nnc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [REQ_W-1:0]         req_type;
   logic signed [FEAT_W-1:0] hu_0;
   logic signed [FEAT_W-1:0] hu_1;
   logic signed [FEAT_W-1:0] hu_2;
   logic signed [FEAT_W-1:0] hu_3;
   logic signed [FEAT_W-1:0] hu_4;
   logic signed [FEAT_W-1:0] hu_5;
   logic signed [FEAT_W-1:0] hu_6;
   logic signed [FEAT_W-1:0] fill_fraction;
   logic signed [FEAT_W-1:0] aspect_ratio;
   logic [CLASS_BITS-1:0]    class_id;

   modport source (
      output valid, req_type, hu_0, hu_1, hu_2, hu_3, hu_4, hu_5, hu_6,
             fill_fraction, aspect_ratio, class_id,
      input  ready
   );
   modport sink (
      input  valid, req_type, hu_0, hu_1, hu_2, hu_3, hu_4, hu_5, hu_6,
             fill_fraction, aspect_ratio, class_id,
      output ready
   );
endinterface

interface nnc_rsp_if #(
   parameter int CLASS_BITS = 8,
   parameter int COUNT_BITS = 7
);
   import nnc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [CLASS_BITS-1:0] best_class;
   logic [DIST_W-1:0]     best_distance_sq;
   logic [COUNT_BITS-1:0] stored_count;

   modport source (
      output valid, status, best_class, best_distance_sq, stored_count,
      input  ready
   );
   modport sink (
      input  valid, status, best_class, best_distance_sq, stored_count,
      output ready
   );
endinterface

@@ rtl/core/nnc_cell.sv @@
// One table entry. During a scan every cell takes the entry of its neighbor.
module nnc_cell #(
   parameter int CLASS_BITS = 8
) (
   input  logic                   clock,
   input  nnc_pkg::cell_ctl_type  ctl,
   input  nnc_pkg::feat_vec_type  load_feat,
   input  logic [CLASS_BITS-1:0]  load_class,
   input  nnc_pkg::feat_vec_type  next_feat,
   input  logic [CLASS_BITS-1:0]  next_class,
   output nnc_pkg::feat_vec_type  cell_feat,
   output logic [CLASS_BITS-1:0]  cell_class
);
   import nnc_pkg::*;

   feat_vec_type          feat_ff;
   feat_vec_type          feat_in;
   logic [CLASS_BITS-1:0] class_ff;
   logic [CLASS_BITS-1:0] class_in;

   always_comb begin
      feat_in  = feat_ff;
      class_in = class_ff;
      if (ctl.write) begin
         feat_in  = load_feat;
         class_in = load_class;
      end else if (ctl.shift) begin
         feat_in  = next_feat;
         class_in = next_class;
      end
   end

   always_ff @(posedge clock) begin
      feat_ff  <= feat_in;
      class_ff <= class_in;
   end

   assign cell_feat  = feat_ff;
   assign cell_class = class_ff;

endmodule

@@ rtl/core/nnc_dist.sv @@
// Four-stage squared Euclidean distance: difference magnitudes, squares,
// sums of three, final sum. The entry class travels alongside.
module nnc_dist #(
   parameter int CLASS_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  nnc_pkg::feat_vec_type         query_feat,
   input  nnc_pkg::feat_vec_type         entry_feat,
   input  logic [CLASS_BITS-1:0]         entry_class,
   output logic                          out_valid,
   output logic [nnc_pkg::DIST_W-1:0]    out_dist,
   output logic [CLASS_BITS-1:0]         out_class,
   output logic                          busy
);
   import nnc_pkg::*;

   localparam int GROUPS = FEAT_COUNT / 3;

   logic [FEAT_COUNT-1:0][FEAT_W-1:0] mag_ff, mag_in;
   logic [FEAT_COUNT-1:0][SQ_W-1:0]   sq_ff, sq_in;
   logic [GROUPS-1:0][PART_W-1:0]     part_ff, part_in;
   logic [DIST_W-1:0]                 dist_ff, dist_in;
   logic [CLASS_BITS-1:0]             cls1_ff, cls2_ff, cls3_ff, cls4_ff;
   logic                              v1_ff, v2_ff, v3_ff, v4_ff;

   always_comb begin
      logic [FEAT_W:0] diff;
      logic [FEAT_W:0] mag;
      for (int i = 0; i < FEAT_COUNT; i++) begin
         diff = {query_feat[i][FEAT_W-1], query_feat[i]}
              - {entry_feat[i][FEAT_W-1], entry_feat[i]};
         mag  = diff[FEAT_W] ? (~diff + 1'b1) : diff;
         mag_in[i] = mag[FEAT_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < FEAT_COUNT; i++) begin
         sq_in[i] = SQ_W'(mag_ff[i]) * SQ_W'(mag_ff[i]);
      end
   end

   always_comb begin
      for (int j = 0; j < GROUPS; j++) begin
         part_in[j] = PART_W'(sq_ff[3*j]) + PART_W'(sq_ff[3*j+1])
                    + PART_W'(sq_ff[3*j+2]);
      end
   end

   always_comb begin
      dist_in = '0;
      for (int j = 0; j < GROUPS; j++) begin
         dist_in = dist_in + DIST_W'(part_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      sq_ff   <= sq_in;
      part_ff <= part_in;
      dist_ff <= dist_in;
      cls1_ff <= entry_class;
      cls2_ff <= cls1_ff;
      cls3_ff <= cls2_ff;
      cls4_ff <= cls3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_dist  = dist_ff;
   assign out_class = cls4_ff;
   assign busy      = v1_ff | v2_ff | v3_ff | v4_ff;

endmodule

@@ rtl/core/nearest_neighbor_classifier.sv @@
// One-nearest-neighbor classifier. The training table lives in a ring of
// MAX_ENTRIES cells, each holding nine signed Q3.20 features and a class.
// A load beat writes the cell at the current fill count, and a clear beat
// resets the count; either goes from idle to the done state for its result.
// A query beat rotates the whole ring once, one cell per cycle, so each
// stored entry passes the head cell in table order and feeds a four-stage
// distance pipeline; the earliest strictly smallest sum of squared
// differences wins. A query's result follows the ring rotation and the
// pipeline drain. One beat is worked on at a time, but a new beat is taken
// while the previous result still waits in the output register.
module nearest_neighbor_classifier #(
   parameter int MAX_ENTRIES = nnc_pkg::MAX_ENTRIES_DEF,
   parameter int CLASS_BITS  = nnc_pkg::CLASS_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   nnc_req_if.sink    req_chan,
   nnc_rsp_if.source  rsp_chan
);
   import nnc_pkg::*;

   // The count must hold the full table size itself.
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_ENTRIES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_ENTRIES);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [IDX_W-1:0]      step_ff, step_in;
   feat_vec_type          query_ff, query_in;
   logic                  found_ff, found_in;
   logic [DIST_W-1:0]     best_dist_ff, best_dist_in;
   logic [CLASS_BITS-1:0] best_class_ff, best_class_in;
   status_type            pend_status_ff, pend_status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CLASS_BITS-1:0] rsp_class_ff, rsp_class_in;
   logic [DIST_W-1:0]     rsp_dist_ff, rsp_dist_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;

   feat_vec_type          req_feat;
   logic                  req_fire;
   logic                  load_fire;
   logic                  scanning;

   feat_vec_type          cell_feat  [MAX_ENTRIES];
   logic [CLASS_BITS-1:0] cell_class [MAX_ENTRIES];

   logic                  dist_valid;
   logic [DIST_W-1:0]     dist_value;
   logic [CLASS_BITS-1:0] dist_class;
   logic                  dist_busy;

   // Gather the beat's features into one vector, first Hu moment at index 0.
   always_comb begin
      req_feat[0] = req_chan.hu_0;
      req_feat[1] = req_chan.hu_1;
      req_feat[2] = req_chan.hu_2;
      req_feat[3] = req_chan.hu_3;
      req_feat[4] = req_chan.hu_4;
      req_feat[5] = req_chan.hu_5;
      req_feat[6] = req_chan.hu_6;
      req_feat[7] = req_chan.fill_fraction;
      req_feat[8] = req_chan.aspect_ratio;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load_fire      = req_fire && (req_chan.req_type == REQ_LOAD)
                           && (total_ff < FULL_CNT);
   assign scanning       = (state_ff == ST_SCAN);

   // The ring: cell i takes the entry of cell i+1, the last wraps to cell 0.
   // After k shifts cell 0 holds entry k; a full turn restores the order.
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_ring
      cell_ctl_type ctl;
      assign ctl.shift = scanning;
      assign ctl.write = load_fire && (total_ff == CNT_W'(i));

      nnc_cell #(
         .CLASS_BITS (CLASS_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .load_feat  (req_feat),
         .load_class (req_chan.class_id),
         .next_feat  (cell_feat[(i + 1) % MAX_ENTRIES]),
         .next_class (cell_class[(i + 1) % MAX_ENTRIES]),
         .cell_feat  (cell_feat[i]),
         .cell_class (cell_class[i])
      );
   end

   // Only entries below the fill count take part in the search.
   nnc_dist #(
      .CLASS_BITS (CLASS_BITS)
   ) u_dist (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (scanning && (CNT_W'(step_ff) < total_ff)),
      .query_feat  (query_ff),
      .entry_feat  (cell_feat[0]),
      .entry_class (cell_class[0]),
      .out_valid   (dist_valid),
      .out_dist    (dist_value),
      .out_class   (dist_class),
      .busy        (dist_busy)
   );

   always_comb begin
      state_in       = state_ff;
      total_in       = total_ff;
      step_in        = step_ff;
      query_in       = query_ff;
      found_in       = found_ff;
      best_dist_in   = best_dist_ff;
      best_class_in  = best_class_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_class_in   = rsp_class_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_count_in   = rsp_count_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               found_in      = 1'b0;
               best_dist_in  = '0;
               best_class_in = '0;
               query_in      = req_feat;
               step_in       = '0;
               state_in      = ST_DONE;
               unique case (req_chan.req_type)
                  REQ_LOAD: begin
                     if (total_ff < FULL_CNT) begin
                        total_in       = total_ff + 1'b1;
                        pend_status_in = STAT_LOADED;
                     end else begin
                        pend_status_in = STAT_FULL;
                     end
                  end
                  REQ_QUERY: begin
                     state_in = ST_SCAN;
                  end
                  REQ_CLEAR: begin
                     total_in       = '0;
                     pend_status_in = STAT_EMPTY;
                  end
                  default: begin
                     // The spare request code leaves the table and count alone and reports empty.
                     pend_status_in = STAT_EMPTY;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Busy covers the last distance, so the best entry is final here.
            if (!dist_busy) begin
               pend_status_in = found_ff ? STAT_ANSWERED : STAT_EMPTY;
               state_in       = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_class_in  = best_class_ff;
               rsp_dist_in   = best_dist_ff;
               rsp_count_in  = total_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Strictly smaller only, so the earliest entry keeps a tie.
      if (dist_valid && (!found_ff || (dist_value < best_dist_ff))) begin
         found_in      = 1'b1;
         best_dist_in  = dist_value;
         best_class_in = dist_class;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff       <= query_in;
      best_dist_ff   <= best_dist_in;
      best_class_ff  <= best_class_in;
      pend_status_ff <= pend_status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_class_ff   <= rsp_class_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.best_class       = rsp_class_ff;
   assign rsp_chan.best_distance_sq = rsp_dist_ff;
   assign rsp_chan.stored_count     = rsp_count_ff;

   // The fill count never passes the table size.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= FULL_CNT)
      else $error("fill count beyond table size");

   // Distances arrive only while a query is scanning or draining.
   a_dist_in_query: assert property (@(posedge clock) disable iff (reset)
      dist_valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance result outside a query");

   // A full turn of the ring ends the scan.
   a_scan_turn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && step_ff == LAST_STEP) |=> (state_ff == ST_DRAIN))
      else $error("scan did not end after one turn");

   // An answered query needs at least one stored entry.
   a_answer_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_ANSWERED) |-> (rsp_count_ff != '0))
      else $error("answer reported on an empty table");

endmodule
